### rtl/ac_ir_frame_decoder_macros.svh
// Assertion helpers shared by the decoder modules; they expect clk and arst_n in scope.
`ifndef AC_IR_FRAME_DECODER_MACROS_SVH
`define AC_IR_FRAME_DECODER_MACROS_SVH

// Same-cycle implication.
`define ACIRD_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("acird assertion failed");

// Next-cycle implication.
`define ACIRD_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("acird assertion failed");

`endif

### rtl/acird_pkg.sv
package acird_pkg;

	localparam int unsigned FRAME_LAST = 20;
	localparam int unsigned POS_W      = 5;

	localparam logic [1:0] STATUS_OK     = 2'd0;
	localparam logic [1:0] STATUS_FIXED  = 2'd1;
	localparam logic [1:0] STATUS_CHKSUM = 2'd2;
	localparam logic [1:0] STATUS_FIELD  = 2'd3;

	localparam logic [7:0] HDR0_VALUE = 8'hC1;
	localparam logic [7:0] HDR1_VALUE = 8'h60;

	typedef struct packed {
		logic [10:0] flag_bits;
		logic [2:0]  sense_temp_code;
		logic [1:0]  fan_level;
		logic [3:0]  set_temperature;
		logic [2:0]  run_mode;
		logic [4:0]  timer_hours;
		logic [1:0]  jet_status;
		logic [7:0]  around_temperature;
		logic [3:0]  sleep_level;
		logic [7:0]  operation_code;
	} fields_t;

	typedef struct packed {
		logic [1:0] status;
		fields_t    fields;
	} result_t;

	typedef logic [6:0] hour_code_t;

	localparam hour_code_t HOUR_CODES [24] = '{
		7'h02, 7'h04, 7'h06, 7'h08, 7'h0A, 7'h0C, 7'h0E, 7'h10,
		7'h12, 7'h14, 7'h15, 7'h16, 7'h17, 7'h18, 7'h19, 7'h1A,
		7'h1B, 7'h1C, 7'h1D, 7'h1E, 7'h1F, 7'h20, 7'h21, 7'h22
	};

	function automatic logic [7:0] bit_rev(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[7 - i] = v[i];
		end
		return r;
	endfunction

	// 1..24 for a known hour code, 0 when the code is not in the table
	function automatic logic [4:0] hour_lookup(input hour_code_t h);
		logic [4:0] hrs;
		hrs = '0;
		for (int i = 0; i < 24; i++) begin
			if (HOUR_CODES[i] == h) begin
				hrs = 5'(i + 1);
			end
		end
		return hrs;
	endfunction

endpackage

### rtl/acird_if.sv
interface acird_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] frame_byte;
	logic       frame_start;

	modport source (output valid, output frame_byte, output frame_start, input ready);
	modport sink   (input valid, input frame_byte, input frame_start, output ready);
endinterface

interface acird_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [10:0] flag_bits;
	logic [2:0]  sense_temp_code;
	logic [1:0]  fan_level;
	logic [3:0]  set_temperature;
	logic [2:0]  run_mode;
	logic [4:0]  timer_hours;
	logic [1:0]  jet_status;
	logic [7:0]  around_temperature;
	logic [3:0]  sleep_level;
	logic [7:0]  operation_code;

	modport source (output valid, output status, output flag_bits, output sense_temp_code,
		output fan_level, output set_temperature, output run_mode, output timer_hours,
		output jet_status, output around_temperature, output sleep_level,
		output operation_code, input ready);
	modport sink (input valid, input status, input flag_bits, input sense_temp_code,
		input fan_level, input set_temperature, input run_mode, input timer_hours,
		input jet_status, input around_temperature, input sleep_level,
		input operation_code, output ready);
endinterface

### rtl/acird_decode.sv
`include "ac_ir_frame_decoder_macros.svh"

module acird_decode (
	input  logic              clk,
	input  logic              arst_n,
	acird_byte_if.sink        byte_in,
	input  logic              can_load,
	output logic              res_valid,
	output acird_pkg::result_t res
);
	import acird_pkg::*;

	localparam logic [POS_W-1:0] POS_HDR0   = POS_W'(0);
	localparam logic [POS_W-1:0] POS_HDR1   = POS_W'(1);
	localparam logic [POS_W-1:0] POS_B2     = POS_W'(2);
	localparam logic [POS_W-1:0] POS_B3     = POS_W'(3);
	localparam logic [POS_W-1:0] POS_B4     = POS_W'(4);
	localparam logic [POS_W-1:0] POS_B5     = POS_W'(5);
	localparam logic [POS_W-1:0] POS_B6     = POS_W'(6);
	localparam logic [POS_W-1:0] POS_Z7     = POS_W'(7);
	localparam logic [POS_W-1:0] POS_B8     = POS_W'(8);
	localparam logic [POS_W-1:0] POS_Z9     = POS_W'(9);
	localparam logic [POS_W-1:0] POS_Z10    = POS_W'(10);
	localparam logic [POS_W-1:0] POS_B11    = POS_W'(11);
	localparam logic [POS_W-1:0] POS_B12    = POS_W'(12);
	localparam logic [POS_W-1:0] POS_CHK1   = POS_W'(13);
	localparam logic [POS_W-1:0] POS_B14    = POS_W'(14);
	localparam logic [POS_W-1:0] POS_B15    = POS_W'(15);
	localparam logic [POS_W-1:0] POS_B16    = POS_W'(16);
	localparam logic [POS_W-1:0] POS_Z17    = POS_W'(17);
	localparam logic [POS_W-1:0] POS_B18    = POS_W'(18);
	localparam logic [POS_W-1:0] POS_Z19    = POS_W'(19);
	localparam logic [POS_W-1:0] POS_CHK2   = POS_W'(FRAME_LAST);

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       start_s1;

	// frame state
	logic [POS_W-1:0] pos_q;
	logic             fixed_ok_q;
	logic [7:0]       xor1_q;
	logic [7:0]       xor2_q;
	logic             cks_ok_q;
	logic             ferr_q;
	fields_t          fields_q;

	logic             restart;
	logic [POS_W-1:0] pos;
	logic             fixed_ok_d;
	logic [7:0]       xor1_d;
	logic [7:0]       xor2_d;
	logic             cks_ok_d;
	logic             ferr_d;
	fields_t          fields_d;
	logic [7:0]       rb;
	logic [4:0]       hrs;
	logic             last;
	logic             advance;

	assign last      = (pos == POS_CHK2);
	assign advance   = valid_s1 && (!last || can_load);
	assign byte_in.ready = !valid_s1 || advance;
	assign res_valid = valid_s1 && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_in.valid && byte_in.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_in.valid && byte_in.ready) begin
			byte_s1  <= byte_in.frame_byte;
			start_s1 <= byte_in.frame_start;
		end
	end

	assign restart = start_s1 || (pos_q == POS_HDR0) || (pos_q > POS_CHK2);
	assign pos     = restart ? POS_HDR0 : pos_q;
	assign rb      = bit_rev(byte_s1);
	assign hrs     = hour_lookup(rb[6:0]);

	always_comb begin
		fixed_ok_d = restart ? 1'b1 : fixed_ok_q;
		xor1_d     = restart ? 8'h00 : xor1_q;
		xor2_d     = restart ? 8'h00 : xor2_q;
		cks_ok_d   = restart ? 1'b1 : cks_ok_q;
		ferr_d     = restart ? 1'b0 : ferr_q;
		fields_d   = restart ? '0 : fields_q;

		unique case (pos) inside
			POS_HDR0: if (byte_s1 != HDR0_VALUE) fixed_ok_d = 1'b0;
			POS_HDR1: if (byte_s1 != HDR1_VALUE) fixed_ok_d = 1'b0;
			POS_Z7, POS_Z9, POS_Z10, POS_Z17, POS_Z19: begin
				if (byte_s1 != 8'h00) fixed_ok_d = 1'b0;
			end
			default: ;
		endcase

		if (pos >= POS_B2 && pos <= POS_B12) begin
			xor1_d = xor1_d ^ byte_s1;
		end else if (pos == POS_CHK1) begin
			if (byte_s1 != xor1_d) cks_ok_d = 1'b0;
		end else if (pos >= POS_B14 && pos <= POS_Z19) begin
			xor2_d = xor2_d ^ byte_s1;
		end else if (pos == POS_CHK2) begin
			if (byte_s1 != xor2_d) cks_ok_d = 1'b0;
		end

		unique case (pos)
			POS_B2: begin
				fields_d.flag_bits[0] = rb[7];
				if (rb[6:4] == 3'd3 || rb[6:4] == 3'd4 || rb[6:4] == 3'd7) ferr_d = 1'b1;
				else fields_d.sense_temp_code = rb[6:4];
				fields_d.flag_bits[1] = rb[3];
				fields_d.flag_bits[2] = rb[2];
				fields_d.fan_level    = rb[1:0];
			end
			POS_B3: begin
				if (rb[7:4] > 4'd14) ferr_d = 1'b1;
				else fields_d.set_temperature = rb[7:4];
				fields_d.flag_bits[3] = rb[3];
				if (rb[2:0] == 3'd3 || rb[2:0] > 3'd4) ferr_d = 1'b1;
				else fields_d.run_mode = rb[2:0];
			end
			POS_B4: begin
				if (rb == 8'h80) fields_d.flag_bits[4] = 1'b1;
				if (rb[6:0] != 7'h00) begin
					if (hrs == 5'd0) ferr_d = 1'b1;
					else fields_d.timer_hours = hrs;
				end
			end
			POS_B5: begin
				if (rb == 8'h90) fields_d.jet_status = 2'd1;
				else if (rb == 8'h10) fields_d.jet_status = 2'd2;
				else if (rb != 8'h00) ferr_d = 1'b1;
			end
			POS_B6: begin
				if (rb == 8'hA0) fields_d.flag_bits[5] = 1'b1;
				else if (rb == 8'h00) fields_d.flag_bits[6] = 1'b1;
				else if (rb != 8'h80) ferr_d = 1'b1;
			end
			POS_B8: begin
				if (rb == 8'h40) fields_d.flag_bits[7] = 1'b1;
				else if (rb != 8'h00) ferr_d = 1'b1;
			end
			POS_B11: begin
				if (rb == 8'h80) fields_d.flag_bits[8] = 1'b1;
				else if (rb != 8'h00) ferr_d = 1'b1;
			end
			POS_B12: fields_d.around_temperature = rb;
			POS_B14: begin
				if (rb[5:4] == 2'b00) fields_d.sleep_level = rb[7:4];
				else ferr_d = 1'b1;
				if (rb[3:0] == 4'd4) fields_d.flag_bits[9] = 1'b1;
				else if (rb[3:0] != 4'd0) ferr_d = 1'b1;
			end
			POS_B15: fields_d.operation_code = rb;
			POS_B16: if (rb != 8'h04 && rb != 8'h00) ferr_d = 1'b1;
			POS_B18: begin
				if (rb == 8'h38) fields_d.flag_bits[10] = 1'b1;
				else if (rb != 8'h28) ferr_d = 1'b1;
			end
			default: ;
		endcase
	end

	always_comb begin
		res.status = !fixed_ok_d ? STATUS_FIXED :
			!cks_ok_d ? STATUS_CHKSUM : ferr_d ? STATUS_FIELD : STATUS_OK;
		res.fields = (res.status == STATUS_OK) ? fields_d : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= POS_HDR0;
			fixed_ok_q <= 1'b1;
			xor1_q     <= 8'h00;
			xor2_q     <= 8'h00;
			cks_ok_q   <= 1'b1;
			ferr_q     <= 1'b0;
			fields_q   <= '0;
		end else if (advance) begin
			pos_q      <= last ? POS_HDR0 : pos + POS_W'(1);
			fixed_ok_q <= fixed_ok_d;
			xor1_q     <= xor1_d;
			xor2_q     <= xor2_d;
			cks_ok_q   <= cks_ok_d;
			ferr_q     <= ferr_d;
			fields_q   <= fields_d;
		end
	end

	`ACIRD_ASSERT_NOW(a_pos_range, 1'b1, pos_q <= POS_CHK2)
	`ACIRD_ASSERT_NEXT(a_wrap_after_last, advance && last, pos_q == POS_HDR0)
	`ACIRD_ASSERT_NEXT(a_start_restarts, advance && start_s1 && !last, pos_q == POS_HDR1)

endmodule

### rtl/acird_out.sv
`include "ac_ir_frame_decoder_macros.svh"

module acird_out (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              res_valid,
	input  acird_pkg::result_t res,
	output logic              can_load,
	acird_result_if.source    result_out
);
	import acird_pkg::*;

	logic    valid_q;
	result_t res_q;
	logic    load;

	assign can_load = !valid_q || result_out.ready;
	assign load     = res_valid && can_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (result_out.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign result_out.valid              = valid_q;
	assign result_out.status             = res_q.status;
	assign result_out.flag_bits          = res_q.fields.flag_bits;
	assign result_out.sense_temp_code    = res_q.fields.sense_temp_code;
	assign result_out.fan_level          = res_q.fields.fan_level;
	assign result_out.set_temperature    = res_q.fields.set_temperature;
	assign result_out.run_mode           = res_q.fields.run_mode;
	assign result_out.timer_hours        = res_q.fields.timer_hours;
	assign result_out.jet_status         = res_q.fields.jet_status;
	assign result_out.around_temperature = res_q.fields.around_temperature;
	assign result_out.sleep_level        = res_q.fields.sleep_level;
	assign result_out.operation_code     = res_q.fields.operation_code;

	`ACIRD_ASSERT_NOW(a_err_zero, valid_q && res_q.status != STATUS_OK, res_q.fields == '0)
	`ACIRD_ASSERT_NOW(a_hours_range, valid_q && res_q.status == STATUS_OK,
		res_q.fields.timer_hours <= 5'd24)
	`ACIRD_ASSERT_NEXT(a_load_shows, load, valid_q && res_q == $past(res))

endmodule

### rtl/ac_ir_frame_decoder.sv
// Channel     Dir   Payload
// byte_in     in    frame_byte[7:0], frame_start
// result_out  out   status[1:0] plus the ten decoded frame fields
//
// One word per cycle, stalls aside: a byte sits in the input register, then updates
// the frame state; byte 20 loads the result register in that same cycle.
// Byte 20 passes the input register, then its result is valid from the result register.
// Reset clears the frame position, so the first byte after reset starts a frame.
// A result waiting in the output register stalls only byte 20 of the next frame.
module ac_ir_frame_decoder (
	input  logic           clk,
	input  logic           arst_n,
	acird_byte_if.sink     byte_in,
	acird_result_if.source result_out
);
	import acird_pkg::*;

	logic    res_valid;
	logic    can_load;
	result_t res;

	acird_decode u_decode (
		.clk      (clk),
		.arst_n   (arst_n),
		.byte_in  (byte_in),
		.can_load (can_load),
		.res_valid(res_valid),
		.res      (res)
	);

	acird_out u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_valid (res_valid),
		.res       (res),
		.can_load  (can_load),
		.result_out(result_out)
	);

endmodule

### bench/acird_tb_codes_pkg.sv
package acird_tb_codes_pkg;

	// Frame byte positions that carry a constant value or a checked field code
	localparam int FIXED_POS [7]  = '{0, 1, 7, 9, 10, 17, 19};
	localparam int FIELD_POS [10] = '{2, 3, 4, 5, 6, 8, 11, 14, 16, 18};
	localparam int HEAD_SUM_POS   = 13;
	localparam int FRAME_BYTES    = 21;

	// Field codes, as seen after bit reversal
	localparam logic [7:0] SIXTH_ON_CODE    = 8'h80;
	localparam logic [7:0] JET_TURN_ON_CODE = 8'h90;
	localparam logic [7:0] JET_ON_CODE      = 8'h10;
	localparam logic [7:0] JET_NONE_CODE    = 8'h00;
	localparam logic [7:0] DIM_CODE         = 8'hA0;
	localparam logic [7:0] KEEPALIVE_CODE   = 8'h00;
	localparam logic [7:0] PLAIN_LIGHT_CODE = 8'h80;
	localparam logic [7:0] SWING2_CODE      = 8'h40;
	localparam logic [7:0] AROUND_ON_CODE   = 8'h80;
	localparam logic [7:0] MINMAX_CODE      = 8'h04;
	localparam logic [7:0] POWER_ON_CODE    = 8'h38;
	localparam logic [7:0] POWER_OFF_CODE   = 8'h28;
	localparam logic [7:0] NO_FLAG_CODE     = 8'h00;
	localparam logic [3:0] SILENT_CODE      = 4'h4;

	// Decoded jet states
	localparam logic [1:0] JET_TURNING_ON = 2'd1;
	localparam logic [1:0] JET_RUNNING    = 2'd2;

	// Bit positions in flag_bits
	localparam int F_SWING     = 0;
	localparam int F_SLEEP     = 1;
	localparam int F_POWER     = 2;
	localparam int F_TIMER     = 3;
	localparam int F_SIXTH     = 4;
	localparam int F_DIM       = 5;
	localparam int F_KEEPALIVE = 6;
	localparam int F_SWING2    = 7;
	localparam int F_AROUND    = 8;
	localparam int F_SILENT    = 9;
	localparam int F_ON_STATE  = 10;

endpackage

### bench/acird_frame_checker.sv
module acird_frame_checker (
	input  logic    clk,
	input  logic    arst_n,
	acird_byte_if   byte_ch,
	acird_result_if result_ch,
	output int      mismatches,
	output int      pending
);
	import acird_pkg::*;
	import acird_tb_codes_pkg::*;

	logic [POS_W-1:0] frame_pos  = '0;
	logic             hdr_ok     = 1'b1;
	logic [7:0]       xor_head   = '0;
	logic [7:0]       xor_tail   = '0;
	logic             sums_ok    = 1'b1;
	logic             code_bad   = 1'b0;
	fields_t          frame_fields = '0;
	result_t          decoded_q [$];

	// Hour code to 1..24; 0 for a code outside the table.
	// Even codes 0x02..0x14 give 1..10, then 0x15..0x22 run one per hour.
	function automatic logic [4:0] hour_of_code(input logic [6:0] code);
		if (code >= 7'h02 && code <= 7'h14 && !code[0])
			return 5'(code >> 1);
		if (code >= 7'h15 && code <= 7'h22)
			return 5'(code - 7'h0A);
		return 5'd0;
	endfunction

	task automatic clear_frame();
		frame_pos    = '0;
		hdr_ok       = 1'b1;
		xor_head     = '0;
		xor_tail     = '0;
		sums_ok      = 1'b1;
		code_bad     = 1'b0;
		frame_fields = '0;
	endtask

	task automatic decode_frame_byte(input logic [7:0] raw, input logic sof);
		logic [7:0] rev;
		logic [4:0] hrs;
		result_t    res;
		if (sof || frame_pos == 0) begin
			clear_frame();
		end
		case (frame_pos)
			0: if (raw != HDR0_VALUE) hdr_ok = 1'b0;
			1: if (raw != HDR1_VALUE) hdr_ok = 1'b0;
			7, 9, 10, 17, 19: if (raw != 8'h00) hdr_ok = 1'b0;
			default: ;
		endcase

		if (frame_pos >= 2 && frame_pos <= 12)
			xor_head ^= raw;
		else if (frame_pos == HEAD_SUM_POS && raw != xor_head)
			sums_ok = 1'b0;
		else if (frame_pos >= 14 && frame_pos <= 19)
			xor_tail ^= raw;
		else if (frame_pos == FRAME_LAST && raw != xor_tail)
			sums_ok = 1'b0;

		rev = {<<{raw}};
		case (frame_pos)
			2: begin
				frame_fields.flag_bits[F_SWING] = rev[7];
				if (rev[6:4] inside {3'd3, 3'd4, 3'd7})
					code_bad = 1'b1;
				else
					frame_fields.sense_temp_code = rev[6:4];
				frame_fields.flag_bits[F_SLEEP] = rev[3];
				frame_fields.flag_bits[F_POWER] = rev[2];
				frame_fields.fan_level = rev[1:0];
			end
			3: begin
				if (rev[7:4] > 4'd14)
					code_bad = 1'b1;
				else
					frame_fields.set_temperature = rev[7:4];
				frame_fields.flag_bits[F_TIMER] = rev[3];
				if (rev[2:0] == 3'd3 || rev[2:0] > 3'd4)
					code_bad = 1'b1;
				else
					frame_fields.run_mode = rev[2:0];
			end
			4: begin
				if (rev == SIXTH_ON_CODE)
					frame_fields.flag_bits[F_SIXTH] = 1'b1;
				if (rev[6:0] != '0) begin
					hrs = hour_of_code(rev[6:0]);
					if (hrs == '0)
						code_bad = 1'b1;
					else
						frame_fields.timer_hours = hrs;
				end
			end
			5: begin
				if (rev == JET_TURN_ON_CODE)
					frame_fields.jet_status = JET_TURNING_ON;
				else if (rev == JET_ON_CODE)
					frame_fields.jet_status = JET_RUNNING;
				else if (rev != JET_NONE_CODE)
					code_bad = 1'b1;
			end
			6: begin
				if (rev == DIM_CODE)
					frame_fields.flag_bits[F_DIM] = 1'b1;
				else if (rev == KEEPALIVE_CODE)
					frame_fields.flag_bits[F_KEEPALIVE] = 1'b1;
				else if (rev != PLAIN_LIGHT_CODE)
					code_bad = 1'b1;
			end
			8: begin
				if (rev == SWING2_CODE)
					frame_fields.flag_bits[F_SWING2] = 1'b1;
				else if (rev != NO_FLAG_CODE)
					code_bad = 1'b1;
			end
			11: begin
				if (rev == AROUND_ON_CODE)
					frame_fields.flag_bits[F_AROUND] = 1'b1;
				else if (rev != NO_FLAG_CODE)
					code_bad = 1'b1;
			end
			12: frame_fields.around_temperature = rev;
			14: begin
				if (rev[7:4] inside {4'd0, 4'd4, 4'd8, 4'd12})
					frame_fields.sleep_level = rev[7:4];
				else
					code_bad = 1'b1;
				if (rev[3:0] == SILENT_CODE)
					frame_fields.flag_bits[F_SILENT] = 1'b1;
				else if (rev[3:0] != 4'h0)
					code_bad = 1'b1;
			end
			15: frame_fields.operation_code = rev;
			// min/max flag is checked but never reported
			16: if (rev != MINMAX_CODE && rev != NO_FLAG_CODE) code_bad = 1'b1;
			18: begin
				if (rev == POWER_ON_CODE)
					frame_fields.flag_bits[F_ON_STATE] = 1'b1;
				else if (rev != POWER_OFF_CODE)
					code_bad = 1'b1;
			end
			default: ;
		endcase

		if (frame_pos < FRAME_LAST) begin
			frame_pos = frame_pos + 1'b1;
		end else begin
			res.status = !hdr_ok ? STATUS_FIXED :
				!sums_ok ? STATUS_CHKSUM :
				code_bad ? STATUS_FIELD : STATUS_OK;
			res.fields = (res.status == STATUS_OK) ? frame_fields : '0;
			decoded_q.push_back(res);
			frame_pos = '0;
		end
	endtask

	function automatic void check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 10)
				$display("t=%0t %s: expected %0d, got %0d", $time, name, want, got);
		end
	endfunction

	task automatic check_result();
		result_t want;
		if (decoded_q.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("t=%0t result word with no frame waiting (status %0d)",
					$time, result_ch.status);
			return;
		end
		want = decoded_q.pop_front();
		check_field("status", want.status, result_ch.status);
		check_field("flag_bits", want.fields.flag_bits, result_ch.flag_bits);
		check_field("sense_temp_code", want.fields.sense_temp_code,
			result_ch.sense_temp_code);
		check_field("fan_level", want.fields.fan_level, result_ch.fan_level);
		check_field("set_temperature", want.fields.set_temperature,
			result_ch.set_temperature);
		check_field("run_mode", want.fields.run_mode, result_ch.run_mode);
		check_field("timer_hours", want.fields.timer_hours, result_ch.timer_hours);
		check_field("jet_status", want.fields.jet_status, result_ch.jet_status);
		check_field("around_temperature", want.fields.around_temperature,
			result_ch.around_temperature);
		check_field("sleep_level", want.fields.sleep_level, result_ch.sleep_level);
		check_field("operation_code", want.fields.operation_code, result_ch.operation_code);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_frame();
			decoded_q.delete();
		end else begin
			if (result_ch.valid && result_ch.ready)
				check_result();
			if (byte_ch.valid && byte_ch.ready)
				decode_frame_byte(byte_ch.frame_byte, byte_ch.frame_start);
		end
		pending = decoded_q.size();
	end

endmodule

### bench/tb_top.sv
module tb_top;
	import acird_pkg::*;
	import acird_tb_codes_pkg::*;

	localparam int BYTE_TARGET = 1550;
	localparam int RUN_LIMIT   = 2000000;

	typedef logic [7:0] ir_frame_t [FRAME_BYTES];
	typedef enum logic [1:0] {RDY_ALWAYS, RDY_COIN, RDY_MOSTLY, RDY_HOLD} rdy_kind_t;

	logic clk = 1'b0;
	logic arst_n;
	int   mismatches;
	int   pending;
	int   bytes_sent = 0;
	int   burst_left = 0;

	acird_byte_if   byte_ch ();
	acird_result_if result_ch ();

	ac_ir_frame_decoder DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_in    (byte_ch),
		.result_out (result_ch)
	);

	acird_frame_checker frame_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_ch    (byte_ch),
		.result_ch  (result_ch),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result side stalls in phases of random kind and length
	rdy_kind_t rdy_kind = RDY_ALWAYS;
	int        rdy_left = 0;

	always @(posedge clk) begin
		if (rdy_left == 0) begin
			rdy_kind = rdy_kind_t'($urandom_range(0, 3));
			rdy_left = $urandom_range(4, 60);
		end else begin
			rdy_left--;
		end
		case (rdy_kind)
			RDY_ALWAYS: result_ch.ready <= 1'b1;
			RDY_COIN:   result_ch.ready <= 1'($urandom_range(0, 1));
			RDY_MOSTLY: result_ch.ready <= ($urandom_range(0, 7) != 0);
			RDY_HOLD:   result_ch.ready <= (rdy_left == 0);
		endcase
	end

	task automatic send_byte(input logic [7:0] b, input logic sof);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : $urandom_range(0, 3);
			if (gap > 0) begin
				byte_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 250)
				: $urandom_range(1, 12);
		end
		byte_ch.valid       <= 1'b1;
		byte_ch.frame_byte  <= b;
		byte_ch.frame_start <= sof;
		@(posedge clk);
		while (!byte_ch.ready) @(posedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_frame(input ir_frame_t fr, input int len, input logic with_sof);
		for (int i = 0; i < len; i++)
			send_byte(fr[i], with_sof && i == 0);
	endtask

	// Hold the byte side until every decoded frame has come out
	task automatic wait_drained();
		byte_ch.valid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (pending != 0);
		@(posedge clk);
	endtask

	// Build a frame from legal field codes; showcase picks the corner values,
	// otherwise the frame may be damaged in fixed bytes, fields or checksums.
	task automatic make_frame(output ir_frame_t fr, input bit showcase);
		logic [7:0] rev [FRAME_BYTES];
		logic [7:0] sum_head;
		logic [7:0] sum_tail;
		int         hrs;
		int         idx;
		for (int i = 0; i < FRAME_BYTES; i++)
			rev[i] = 8'h00;

		rev[2][7]   = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 4))
			0: rev[2][6:4] = 3'd0;
			1: rev[2][6:4] = 3'd1;
			2: rev[2][6:4] = 3'd2;
			3: rev[2][6:4] = 3'd5;
			default: rev[2][6:4] = 3'd6;
		endcase
		rev[2][3:0] = 4'($urandom_range(0, 15));
		rev[3][7:4] = 4'($urandom_range(0, 14));
		rev[3][3]   = 1'($urandom_range(0, 1));
		case ($urandom_range(0, 3))
			0: rev[3][2:0] = 3'd0;
			1: rev[3][2:0] = 3'd1;
			2: rev[3][2:0] = 3'd2;
			default: rev[3][2:0] = 3'd4;
		endcase
		if ($urandom_range(0, 7) == 0) begin
			rev[4] = SIXTH_ON_CODE;
		end else begin
			rev[4][7] = 1'($urandom_range(0, 1));
			if ($urandom_range(0, 3) != 0) begin
				hrs = $urandom_range(1, 24);
				rev[4][6:0] = 7'((hrs <= 10) ? 2 * hrs : hrs + 10);
			end
		end
		case ($urandom_range(0, 2))
			0: rev[5] = JET_NONE_CODE;
			1: rev[5] = JET_TURN_ON_CODE;
			default: rev[5] = JET_ON_CODE;
		endcase
		case ($urandom_range(0, 2))
			0: rev[6] = DIM_CODE;
			1: rev[6] = KEEPALIVE_CODE;
			default: rev[6] = PLAIN_LIGHT_CODE;
		endcase
		rev[8]  = $urandom_range(0, 1) ? SWING2_CODE : NO_FLAG_CODE;
		rev[11] = $urandom_range(0, 1) ? AROUND_ON_CODE : NO_FLAG_CODE;
		rev[12] = 8'($urandom_range(0, 255));
		rev[14] = {4'(4 * $urandom_range(0, 3)), $urandom_range(0, 1) ? SILENT_CODE : 4'h0};
		rev[15] = 8'($urandom_range(0, 255));
		rev[16] = $urandom_range(0, 1) ? MINMAX_CODE : NO_FLAG_CODE;
		rev[18] = $urandom_range(0, 1) ? POWER_ON_CODE : POWER_OFF_CODE;

		if (showcase) begin
			rev[2]  = 8'hEF;
			rev[3]  = 8'hEC;
			rev[4]  = SIXTH_ON_CODE;
			rev[5]  = JET_TURN_ON_CODE;
			rev[6]  = PLAIN_LIGHT_CODE;
			rev[8]  = SWING2_CODE;
			rev[11] = AROUND_ON_CODE;
			rev[12] = 8'hFF;
			rev[14] = {4'd12, SILENT_CODE};
			rev[15] = 8'h00;
			rev[16] = MINMAX_CODE;
			rev[18] = POWER_ON_CODE;
		end

		for (int i = 0; i < FRAME_BYTES; i++)
			fr[i] = {<<{rev[i]}};
		fr[0] = HDR0_VALUE;
		fr[1] = HDR1_VALUE;

		if (!showcase) begin
			if ($urandom_range(0, 7) == 0) begin
				idx = FIXED_POS[$urandom_range(0, 6)];
				fr[idx] ^= 8'($urandom_range(1, 255));
			end
			if ($urandom_range(0, 5) == 0) begin
				idx = FIELD_POS[$urandom_range(0, 9)];
				fr[idx] = 8'($urandom_range(0, 255));
			end
			if ($urandom_range(0, 9) == 0) begin
				idx = $urandom_range(0, FRAME_BYTES - 1);
				fr[idx] = 8'($urandom_range(0, 255));
			end
		end

		sum_head = '0;
		sum_tail = '0;
		for (int i = 2; i <= 12; i++)
			sum_head ^= fr[i];
		for (int i = 14; i <= 19; i++)
			sum_tail ^= fr[i];
		fr[HEAD_SUM_POS] = sum_head;
		fr[FRAME_LAST]   = sum_tail;

		if (!showcase && $urandom_range(0, 7) == 0) begin
			idx = $urandom_range(0, 1) ? HEAD_SUM_POS : FRAME_LAST;
			fr[idx] ^= 8'($urandom_range(1, 255));
		end
	endtask

	initial begin
		#(RUN_LIMIT);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		ir_frame_t fr;
		int        pick;
		bit        paused;
		paused = 1'b0;
		arst_n              <= 1'b0;
		byte_ch.valid       <= 1'b0;
		byte_ch.frame_byte  <= 8'h00;
		byte_ch.frame_start <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// First bytes after reset carry no start marker; the marker below drops them
		send_byte(HDR0_VALUE, 1'b0);
		send_byte(HDR1_VALUE, 1'b0);
		send_byte(8'hFF, 1'b0);
		make_frame(fr, 1'b1);
		send_frame(fr, FRAME_BYTES, 1'b1);

		while (bytes_sent < BYTE_TARGET) begin
			pick = $urandom_range(0, 99);
			make_frame(fr, 1'b0);
			if (pick < 75) begin
				send_frame(fr, FRAME_BYTES, 1'b1);
			end else if (pick < 85) begin
				send_frame(fr, $urandom_range(1, FRAME_BYTES - 1), 1'b1);
			end else if (pick < 90) begin
				send_frame(fr, FRAME_BYTES, 1'b0);
			end else begin
				repeat ($urandom_range(1, 25))
					send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 7) == 0));
			end
			if (!paused && bytes_sent > BYTE_TARGET / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
